// File: design/tpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_pkg
// Shared types, constants and helper functions for the three-point angle core.
// ----------------------------------------------------------------------------
package tpa_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS   = 32;

  // Pi in Q2.30 and the largest angle code in Q2.16.
  localparam logic [33:0] PI_Q30    = 34'd3373259426;
  localparam logic [17:0] ANGLE_MAX = 18'd205887;
  localparam logic [34:0] ROUND_Q14 = 35'd8192;

  typedef logic signed [60:0] tpa_xy_t;
  typedef logic signed [34:0] tpa_z_t;

  // Control that travels beside the data through every stage.
  typedef struct packed {
    logic valid;
    logic degen;
    logic dneg;
  } tpa_side_t;

  // One input beat: the three points.
  typedef struct packed {
    logic signed [31:0] p1_x;
    logic signed [31:0] p1_y;
    logic signed [31:0] p1_z;
    logic signed [31:0] p2_x;
    logic signed [31:0] p2_y;
    logic signed [31:0] p2_z;
    logic signed [31:0] p3_x;
    logic signed [31:0] p3_y;
    logic signed [31:0] p3_z;
  } tpa_pts_t;

  // atan(2^-i) in Q2.30.
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd843314856;
      5'd1:  v = 32'd497837829;
      5'd2:  v = 32'd263043836;
      5'd3:  v = 32'd133525158;
      5'd4:  v = 32'd66908022;
      5'd5:  v = 32'd33549659;
      5'd6:  v = 32'd16775850;
      5'd7:  v = 32'd8388437;
      5'd8:  v = 32'd4194282;
      5'd9:  v = 32'd2097149;
      5'd10: v = 32'd1048575;
      5'd11: v = 32'd524287;
      5'd12: v = 32'd262143;
      5'd13: v = 32'd131071;
      5'd14: v = 32'd65535;
      5'd15: v = 32'd32767;
      5'd16: v = 32'd16383;
      5'd17: v = 32'd8191;
      5'd18: v = 32'd4095;
      5'd19: v = 32'd2047;
      5'd20: v = 32'd1023;
      5'd21: v = 32'd511;
      5'd22: v = 32'd255;
      5'd23: v = 32'd127;
      5'd24: v = 32'd63;
      5'd25: v = 32'd31;
      5'd26: v = 32'd15;
      5'd27: v = 32'd8;
      5'd28: v = 32'd4;
      5'd29: v = 32'd2;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Position of the highest set bit plus one; zero for a zero word.
  function automatic logic [6:0] bit_len(input logic [63:0] v);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 7'(i + 1);
    end
    return n;
  endfunction

endpackage

// File: design/tpa_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_in_if / tpa_out_if
// Valid/ready channels carrying the point triple and the angle result.
// ----------------------------------------------------------------------------
interface tpa_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] p1_x;
  logic signed [31:0] p1_y;
  logic signed [31:0] p1_z;
  logic signed [31:0] p2_x;
  logic signed [31:0] p2_y;
  logic signed [31:0] p2_z;
  logic signed [31:0] p3_x;
  logic signed [31:0] p3_y;
  logic signed [31:0] p3_z;

  modport source (output valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
                  input ready);
  modport sink (input valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
                output ready);
endinterface

interface tpa_out_if;
  logic        valid;
  logic        ready;
  logic [17:0] angle_rad;
  logic        degenerate;

  modport source (output valid, angle_rad, degenerate, input ready);
  modport sink (input valid, angle_rad, degenerate, output ready);
endinterface

// File: design/three_point_angle_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_point_angle_core
// Angle at the middle of three 3-D points, unsigned Q2.16 radians, built as
// a normalizing front end, a row of square-root cells and a row of CORDIC
// cells.
//
//   channel   direction  beat contents
//   in_ch     sink       p1_x..p3_z, nine signed 32-bit coordinates
//   out_ch    source     angle_rad (18 bits), degenerate (1 bit)
//
// One beat is accepted per cycle while the pipeline advances; a beat passes
// 9 front stages, 32 square-root cells, 2 scaling stages, 30 CORDIC cells
// and the output register. The whole pipeline advances together; it holds only
// while a finished beat waits at the output and the sink is not ready.
// Reset (synchronous, active low) clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module three_point_angle_core
  import tpa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  tpa_in_if.sink     in_ch,
  tpa_out_if.source  out_ch
);

  logic        adv;
  tpa_pts_t    pts;
  logic        out_valid_r;
  logic [17:0] angle_r, angle_nxt;
  logic        degen_r;

  tpa_side_t   sq_side [SQRT_STEPS+1];
  logic [63:0] sq_n    [SQRT_STEPS+1];
  logic [34:0] sq_rem  [SQRT_STEPS+1];
  logic [31:0] sq_root [SQRT_STEPS+1];
  logic [62:0] sq_x    [SQRT_STEPS+1];

  tpa_side_t   t1_side_r, t2_side_r;
  logic [62:0] t1_x_r;
  logic [31:0] t1_y_r;
  logic [5:0]  t1_sh_r, t_sh;
  logic [6:0]  t_len;
  logic [62:0] xt;
  logic [31:0] yt;
  tpa_xy_t     t2_x_r, t2_y_r;

  tpa_side_t   co_side [CORDIC_STEPS+1];
  tpa_xy_t     co_x    [CORDIC_STEPS+1];
  tpa_xy_t     co_y    [CORDIC_STEPS+1];
  tpa_z_t      co_z    [CORDIC_STEPS+1];

  tpa_z_t      zf, zc;
  logic [34:0] zr;

  // Pipeline advance: move whenever the output slot is free or being taken.
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  assign pts = '{p1_x: in_ch.p1_x, p1_y: in_ch.p1_y, p1_z: in_ch.p1_z,
                 p2_x: in_ch.p2_x, p2_y: in_ch.p2_y, p2_z: in_ch.p2_z,
                 p3_x: in_ch.p3_x, p3_y: in_ch.p3_y, p3_z: in_ch.p3_z};

  tpa_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_ch.valid),
    .pts      (pts),
    .side_o   (sq_side[0]),
    .sq_o     (sq_n[0]),
    .x_o      (sq_x[0])
  );

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  // Square root of the squared cross-product length, one root bit per cell.
  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    tpa_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .side_i (sq_side[g]),
      .n_i    (sq_n[g]),
      .rem_i  (sq_rem[g]),
      .root_i (sq_root[g]),
      .x_i    (sq_x[g]),
      .side_o (sq_side[g+1]),
      .n_o    (sq_n[g+1]),
      .rem_o  (sq_rem[g+1]),
      .root_o (sq_root[g+1]),
      .x_o    (sq_x[g+1])
    );
  end

  // Shift that keeps both CORDIC operands within 32 bits.
  always_comb begin
    t_len = bit_len({1'b0, sq_x[SQRT_STEPS]});
    t_sh  = (t_len > 7'd32) ? 6'(t_len - 7'd32) : 6'd0;
    xt    = t1_x_r >> t1_sh_r;
    yt    = t1_y_r >> t1_sh_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_side_r <= '0;
      t2_side_r <= '0;
    end else if (adv) begin
      t1_side_r <= sq_side[SQRT_STEPS];
      t2_side_r <= t1_side_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_x_r  <= sq_x[SQRT_STEPS];
      t1_y_r  <= sq_root[SQRT_STEPS];
      t1_sh_r <= t_sh;
      t2_x_r  <= $signed({5'b00000, xt[31:0], 24'd0});
      t2_y_r  <= $signed({5'b00000, yt, 24'd0});
    end
  end

  assign co_side[0] = t2_side_r;
  assign co_x[0]    = t2_x_r;
  assign co_y[0]    = t2_y_r;
  assign co_z[0]    = '0;

  // CORDIC vectoring row, one rotation per cell.
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    tpa_cordic_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .step   (5'(g)),
      .side_i (co_side[g]),
      .x_i    (co_x[g]),
      .y_i    (co_y[g]),
      .z_i    (co_z[g]),
      .side_o (co_side[g+1]),
      .x_o    (co_x[g+1]),
      .y_o    (co_y[g+1]),
      .z_o    (co_z[g+1])
    );
  end

  // Obtuse fold, clamp to [0, pi], round to Q2.16; a degenerate beat gives zero.
  always_comb begin
    zf = co_side[CORDIC_STEPS].dneg ? ($signed({1'b0, PI_Q30}) - co_z[CORDIC_STEPS])
                                    : co_z[CORDIC_STEPS];
    if (zf[34]) begin
      zc = '0;
    end else if (zf > $signed({1'b0, PI_Q30})) begin
      zc = $signed({1'b0, PI_Q30});
    end else begin
      zc = zf;
    end
    zr = (35'(zc) + ROUND_Q14) >> 14;
    if (co_side[CORDIC_STEPS].degen) begin
      angle_nxt = '0;
    end else if (zr > 35'(ANGLE_MAX)) begin
      angle_nxt = ANGLE_MAX;
    end else begin
      angle_nxt = zr[17:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= co_side[CORDIC_STEPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      angle_r <= angle_nxt;
      degen_r <= co_side[CORDIC_STEPS].degen;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.angle_rad  = angle_r;
  assign out_ch.degenerate = degen_r;

`ifndef NO_ASSERTIONS
  // A degenerate beat always reports a zero angle.
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && degen_r |-> angle_r == '0)
    else $error("degenerate beat with nonzero angle");

  // The angle never exceeds pi.
  a_angle_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> angle_r <= ANGLE_MAX)
    else $error("angle above pi");

  // The CORDIC operands entering the row fit in 56 bits.
  a_cordic_in: assert property (@(posedge clk) disable iff (!rst_n)
    t2_side_r.valid |-> t2_x_r[60:56] == '0 && t2_y_r[60:56] == '0)
    else $error("CORDIC operand out of range");
`endif

endmodule

// File: design/tpa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_front
// Difference vectors, power-of-two normalization, dot and cross products,
// and the squared cross-product length, in nine pipeline stages.
// ----------------------------------------------------------------------------
module tpa_front
  import tpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_valid,
  input  tpa_pts_t    pts,
  output tpa_side_t   side_o,
  output logic [63:0] sq_o,
  output logic [62:0] x_o
);

  tpa_side_t          s1_r, s2_r, s3_r, s4_r, s5_r, s6_r, s7_r, s8_r, s9_r;
  logic [32:0]        ma1_r [3], mb1_r [3], ma2_r [3], mb2_r [3];
  logic [2:0]         sa1_r, sb1_r, sa2_r, sb2_r;
  logic [5:0]         na2_r, nb2_r;
  logic signed [30:0] av3_r [3], bv3_r [3];
  logic signed [61:0] pr4_r [9];
  logic [61:0]        mc5_r [3], mc6_r [3];
  logic [62:0]        dm5_r, dm6_r;
  logic [5:0]         s6_sh_r;
  logic [30:0]        q7_r [3];
  logic [62:0]        x7_r, x8_r, x9_r;
  logic [61:0]        sqk8_r [3];
  logic [63:0]        sq9_r;

  logic signed [32:0] a_d [3], b_d [3];
  logic               degen_d;
  logic [32:0]        mxa_d, mxb_d;
  logic [5:0]         na_d, nb_d;
  logic signed [30:0] av_d [3], bv_d [3];
  logic signed [63:0] d_d, c_d [3];
  logic [61:0]        mxc_d;
  logic [6:0]         nc_d;
  logic [5:0]         sc_d;

  // Stage 1: difference vectors and the zero-length check.
  always_comb begin
    a_d[0] = 33'(pts.p1_x) - 33'(pts.p2_x);
    a_d[1] = 33'(pts.p1_y) - 33'(pts.p2_y);
    a_d[2] = 33'(pts.p1_z) - 33'(pts.p2_z);
    b_d[0] = 33'(pts.p3_x) - 33'(pts.p2_x);
    b_d[1] = 33'(pts.p3_y) - 33'(pts.p2_y);
    b_d[2] = 33'(pts.p3_z) - 33'(pts.p2_z);
    degen_d = (a_d[0] == 0 && a_d[1] == 0 && a_d[2] == 0) ||
              (b_d[0] == 0 && b_d[1] == 0 && b_d[2] == 0);
  end

  // Stage 2: largest magnitude of each vector.
  always_comb begin
    mxa_d = ma1_r[0];
    mxb_d = mb1_r[0];
    for (int k = 1; k < 3; k++) begin
      if (ma1_r[k] > mxa_d) mxa_d = ma1_r[k];
      if (mb1_r[k] > mxb_d) mxb_d = mb1_r[k];
    end
    na_d = 6'(bit_len(64'(mxa_d)));
    nb_d = 6'(bit_len(64'(mxb_d)));
  end

  // Stage 3: shift each vector so that its largest magnitude has 30 bits.
  always_comb begin
    logic [32:0] ta, tb;
    for (int k = 0; k < 3; k++) begin
      ta = (na2_r > 6'd30) ? (ma2_r[k] >> (na2_r - 6'd30)) : (ma2_r[k] << (6'd30 - na2_r));
      tb = (nb2_r > 6'd30) ? (mb2_r[k] >> (nb2_r - 6'd30)) : (mb2_r[k] << (6'd30 - nb2_r));
      av_d[k] = sa2_r[k] ? -$signed({1'b0, ta[29:0]}) : $signed({1'b0, ta[29:0]});
      bv_d[k] = sb2_r[k] ? -$signed({1'b0, tb[29:0]}) : $signed({1'b0, tb[29:0]});
    end
  end

  // Stage 5: dot product and cross product.
  always_comb begin
    d_d    = 64'(pr4_r[0]) + 64'(pr4_r[1]) + 64'(pr4_r[2]);
    c_d[0] = 64'(pr4_r[3]) - 64'(pr4_r[4]);
    c_d[1] = 64'(pr4_r[5]) - 64'(pr4_r[6]);
    c_d[2] = 64'(pr4_r[7]) - 64'(pr4_r[8]);
  end

  // Stage 6: shift that brings the cross product below 2^31.
  always_comb begin
    mxc_d = mc5_r[0];
    for (int k = 1; k < 3; k++) begin
      if (mc5_r[k] > mxc_d) mxc_d = mc5_r[k];
    end
    nc_d = bit_len(64'(mxc_d));
    sc_d = (nc_d > 7'd31) ? 6'(nc_d - 7'd31) : 6'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
      s3_r <= '0;
      s4_r <= '0;
      s5_r <= '0;
      s6_r <= '0;
      s7_r <= '0;
      s8_r <= '0;
      s9_r <= '0;
    end else if (adv) begin
      s1_r <= '{valid: in_valid, degen: degen_d, dneg: 1'b0};
      s2_r <= s1_r;
      s3_r <= s2_r;
      s4_r <= s3_r;
      s5_r <= '{valid: s4_r.valid, degen: s4_r.degen, dneg: d_d[63]};
      s6_r <= s5_r;
      s7_r <= s6_r;
      s8_r <= s7_r;
      s9_r <= s8_r;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        sa1_r[k] <= a_d[k][32];
        sb1_r[k] <= b_d[k][32];
        ma1_r[k] <= a_d[k][32] ? 33'(-a_d[k]) : 33'(a_d[k]);
        mb1_r[k] <= b_d[k][32] ? 33'(-b_d[k]) : 33'(b_d[k]);
        ma2_r[k] <= ma1_r[k];
        mb2_r[k] <= mb1_r[k];
        av3_r[k] <= av_d[k];
        bv3_r[k] <= bv_d[k];
        mc5_r[k] <= c_d[k][63] ? 62'(-c_d[k]) : 62'(c_d[k]);
        mc6_r[k] <= mc5_r[k];
        q7_r[k]  <= 31'(mc6_r[k] >> s6_sh_r);
        sqk8_r[k] <= q7_r[k] * q7_r[k];
      end
      sa2_r   <= sa1_r;
      sb2_r   <= sb1_r;
      na2_r   <= na_d;
      nb2_r   <= nb_d;
      pr4_r[0] <= av3_r[0] * bv3_r[0];
      pr4_r[1] <= av3_r[1] * bv3_r[1];
      pr4_r[2] <= av3_r[2] * bv3_r[2];
      pr4_r[3] <= av3_r[1] * bv3_r[2];
      pr4_r[4] <= av3_r[2] * bv3_r[1];
      pr4_r[5] <= av3_r[2] * bv3_r[0];
      pr4_r[6] <= av3_r[0] * bv3_r[2];
      pr4_r[7] <= av3_r[0] * bv3_r[1];
      pr4_r[8] <= av3_r[1] * bv3_r[0];
      dm5_r   <= d_d[63] ? 63'(-d_d) : 63'(d_d);
      dm6_r   <= dm5_r;
      s6_sh_r <= sc_d;
      x7_r    <= dm6_r >> s6_sh_r;
      x8_r    <= x7_r;
      x9_r    <= x8_r;
      sq9_r   <= 64'(sqk8_r[0]) + 64'(sqk8_r[1]) + 64'(sqk8_r[2]);
    end
  end

  assign side_o = s9_r;
  assign sq_o   = sq9_r;
  assign x_o    = x9_r;

endmodule

// File: design/tpa_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_sqrt_cell
// One digit of a restoring integer square root: takes two radicand bits and
// settles one root bit, then hands the partial result to the next cell.
// ----------------------------------------------------------------------------
module tpa_sqrt_cell
  import tpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  tpa_side_t   side_i,
  input  logic [63:0] n_i,
  input  logic [34:0] rem_i,
  input  logic [31:0] root_i,
  input  logic [62:0] x_i,
  output tpa_side_t   side_o,
  output logic [63:0] n_o,
  output logic [34:0] rem_o,
  output logic [31:0] root_o,
  output logic [62:0] x_o
);

  tpa_side_t   side_r;
  logic [63:0] n_r;
  logic [34:0] rem_r, rem_nxt, rem_sh, trial;
  logic [31:0] root_r, root_nxt;
  logic [62:0] x_r;

  // Trial subtraction of 4*root + 1 from the shifted remainder.
  always_comb begin
    rem_sh = {rem_i[32:0], n_i[63:62]};
    trial  = {1'b0, root_i, 2'b01};
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {root_i[30:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {root_i[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= '0;
    end else if (adv) begin
      side_r <= side_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_r    <= {n_i[61:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      x_r    <= x_i;
    end
  end

  assign side_o = side_r;
  assign n_o    = n_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign x_o    = x_r;

`ifndef NO_ASSERTIONS
  // The remainder never exceeds twice the partial root.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    side_r.valid |-> rem_r <= {2'b00, root_r, 1'b0})
    else $error("sqrt remainder exceeds twice the root");
`endif

endmodule

// File: design/tpa_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_cordic_cell
// One CORDIC vectoring rotation: drives y toward zero and accumulates the
// rotation angle, then hands x, y and z to the next cell.
// ----------------------------------------------------------------------------
module tpa_cordic_cell
  import tpa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  logic [4:0] step,
  input  tpa_side_t  side_i,
  input  tpa_xy_t    x_i,
  input  tpa_xy_t    y_i,
  input  tpa_z_t     z_i,
  output tpa_side_t  side_o,
  output tpa_xy_t    x_o,
  output tpa_xy_t    y_o,
  output tpa_z_t     z_o
);

  tpa_side_t side_r;
  tpa_xy_t   x_r, y_r, x_nxt, y_nxt, xs, ys;
  tpa_z_t    z_r, z_nxt, ang;

  // Rotate by plus or minus atan(2^-step) according to the sign of y.
  always_comb begin
    xs  = x_i >>> step;
    ys  = y_i >>> step;
    ang = $signed({3'b000, atan_q30(step)});
    if (!y_i[60]) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ang;
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= '0;
    end else if (adv) begin
      side_r <= side_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign side_o = side_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;

`ifndef NO_ASSERTIONS
  // In vectoring mode x only grows from a non-negative start.
  a_x_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    side_r.valid && !side_r.degen |-> !x_r[60])
    else $error("CORDIC x went negative");
`endif

endmodule

// File: tb/tpa_angle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_angle_checker
// Watches both channels of the three-point angle core. For every accepted
// input beat it computes the expected angle and degenerate flag in fixed
// point and queues them. Every accepted output beat is compared with the oldest entry.
// ----------------------------------------------------------------------------
module tpa_angle_checker
  import tpa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  tpa_in_if    in_ch,
  tpa_out_if   out_ch,
  output int   fail_count,
  output int   pending_angles
);

  typedef struct packed {
    logic [17:0] angle_rad;
    logic        degenerate;
  } angle_res_t;

  angle_res_t angle_q[$];

  localparam longint unsigned PI_FIX = 64'd3373259426;
  localparam longint unsigned ANGLE_TOP = 64'd205887;

  // Table of atan(2^-i) in Q2.30.
  localparam longint ATAN_TBL[30] = '{
    843314856, 497837829, 263043836, 133525158, 66908022, 33549659,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
    127, 63, 31, 15, 8, 4, 2};

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? 64'd0 - longint'(v) : longint'(v);
  endfunction

  // Power-of-two scaling of one vector so that its largest part lands
  // in [2^29, 2^30).
  function automatic void normalize_vec(ref longint v[3]);
    longint unsigned m[3];
    longint unsigned mx;
    int r;
    int l;
    mx = 0;
    r = 0;
    l = 0;
    for (int k = 0; k < 3; k++) begin
      m[k] = abs64(v[k]);
      if (m[k] > mx) mx = m[k];
    end
    while ((mx >> r) >= (64'd1 << 30)) r++;
    if (r == 0 && mx != 0)
      while ((mx << l) < (64'd1 << 29)) l++;
    for (int k = 0; k < 3; k++) begin
      m[k] = (m[k] >> r) << l;
      v[k] = (v[k] < 0) ? -longint'(m[k]) : longint'(m[k]);
    end
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Expected angle at the vertex for one point triple.
  function automatic angle_res_t vertex_angle(tpa_pts_t p);
    angle_res_t   res;
    longint       a[3];
    longint       b[3];
    longint       c[3];
    longint       d;
    longint       z;
    longint       x;
    longint       y;
    longint       xn;
    longint unsigned mc[3];
    longint unsigned mxc;
    longint unsigned sq;
    longint unsigned ux;
    longint unsigned uy;
    int s;
    int t;
    a[0] = longint'(p.p1_x) - longint'(p.p2_x);
    a[1] = longint'(p.p1_y) - longint'(p.p2_y);
    a[2] = longint'(p.p1_z) - longint'(p.p2_z);
    b[0] = longint'(p.p3_x) - longint'(p.p2_x);
    b[1] = longint'(p.p3_y) - longint'(p.p2_y);
    b[2] = longint'(p.p3_z) - longint'(p.p2_z);
    res = '0;
    if ((a[0] == 0 && a[1] == 0 && a[2] == 0) ||
        (b[0] == 0 && b[1] == 0 && b[2] == 0)) begin
      res.degenerate = 1'b1;
      return res;
    end
    normalize_vec(a);
    normalize_vec(b);
    d = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
    mxc = 0;
    for (int k = 0; k < 3; k++) begin
      mc[k] = abs64(c[k]);
      if (mc[k] > mxc) mxc = mc[k];
    end
    s = 0;
    while ((mxc >> s) >= (64'd1 << 31)) s++;
    sq = 0;
    for (int k = 0; k < 3; k++) sq += (mc[k] >> s) * (mc[k] >> s);
    uy = floor_sqrt(sq);
    ux = abs64(d) >> s;
    t = 0;
    while ((ux >> t) >= (64'd1 << 32) || (uy >> t) >= (64'd1 << 32)) t++;
    x = longint'((ux >> t) << 24);
    y = longint'((uy >> t) << 24);
    // CORDIC vectoring toward the x axis.
    z = 0;
    for (int i = 0; i < 30; i++) begin
      if (y >= 0) begin
        xn = x + (y >>> i);
        y  = y - longint'(longint'(unsigned'(x)) >> i);
        z += ATAN_TBL[i];
      end else begin
        xn = x - (y >>> i);
        y  = y + longint'(longint'(unsigned'(x)) >> i);
        z -= ATAN_TBL[i];
      end
      x = xn;
    end
    if (d < 0) z = longint'(PI_FIX) - z;
    if (z < 0) z = 0;
    if (z > longint'(PI_FIX)) z = longint'(PI_FIX);
    ux = (longint'(unsigned'(z)) + 64'd8192) >> 14;
    if (ux > ANGLE_TOP) ux = ANGLE_TOP;
    res.angle_rad = ux[17:0];
    return res;
  endfunction

  assign pending_angles = angle_q.size();

  // Predict on input beats, compare on output beats.
  always @(posedge clk) begin
    tpa_pts_t   pts;
    angle_res_t want;
    if (!rst_n) begin
      angle_q.delete();
      fail_count <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        pts = '{in_ch.p1_x, in_ch.p1_y, in_ch.p1_z, in_ch.p2_x, in_ch.p2_y,
                in_ch.p2_z, in_ch.p3_x, in_ch.p3_y, in_ch.p3_z};
        angle_q.push_back(vertex_angle(pts));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (angle_q.size() == 0) begin
          if (fail_count < 10)
            $display("ERROR: output beat with no prediction: angle %0d degen %0b",
                     out_ch.angle_rad, out_ch.degenerate);
          fail_count <= fail_count + 1;
        end else begin
          want = angle_q.pop_front();
          if (want.angle_rad !== out_ch.angle_rad ||
              want.degenerate !== out_ch.degenerate) begin
            if (fail_count < 10)
              $display("ERROR: angle exp %0d got %0d, degen exp %0b got %0b",
                       want.angle_rad, out_ch.angle_rad, want.degenerate,
                       out_ch.degenerate);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// File: tb/tb_three_point_angle_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_point_angle_core
// Drives directed and random point triples into the angle core under
// several idle and stall patterns, including one long output hold-off,
// and reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb_three_point_angle_core;
  import tpa_pkg::*;

  localparam int LATENCY     = 74;
  localparam int WATCH_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending_angles;
  int   send_idle_pct = 0;
  int   sink_stall_pct = 0;
  logic hold_off = 1'b0;
  int   quiet_cycles = 0;

  tpa_in_if  in_ch();
  tpa_out_if out_ch();

  three_point_angle_core dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  tpa_angle_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending_angles(pending_angles)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, or a forced hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_off && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watchdog on cycles with no accepted beat.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Send one beat, keeping valid high across back-to-back beats.
  task automatic send_points(tpa_pts_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.p1_x, in_ch.p1_y, in_ch.p1_z, in_ch.p2_x, in_ch.p2_y, in_ch.p2_z,
     in_ch.p3_x, in_ch.p3_y, in_ch.p3_z} <= p;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic logic [31:0] coord_rand(int mode);
    case (mode)
      0:       return $urandom;
      1:       return 32'($signed($urandom_range(32)) - 16);
      2:       return 32'($signed($urandom_range(2000000)) - 1000000);
      default: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(3)
                                        : 32'h80000000 + $urandom_range(3);
    endcase
  endfunction

  // Random triple: mostly general, some with shared or aligned points or a right angle.
  function automatic tpa_pts_t random_points();
    tpa_pts_t p;
    int mode;
    int shape;
    logic [31:0] q[9];
    mode = $urandom_range(3);
    shape = $urandom_range(9);
    for (int k = 0; k < 9; k++) q[k] = coord_rand(mode);
    if (shape == 0) begin
      q[0] = q[3]; q[1] = q[4]; q[2] = q[5];
    end else if (shape == 1) begin
      q[6] = q[3]; q[7] = q[4]; q[8] = q[5];
    end else if (shape == 2) begin
      // Third point on the line through the first two, beyond the second point.
      for (int k = 0; k < 3; k++) q[6 + k] = q[3 + k] - (q[k] - q[3 + k]) * 2;
    end else if (shape == 3) begin
      // Right angle in the xy plane.
      q[0] = q[3] + q[7] - q[4];
      q[1] = q[4] - (q[6] - q[3]);
      q[2] = q[5]; q[8] = q[5];
    end
    p = {q[0], q[1], q[2], q[3], q[4], q[5], q[6], q[7], q[8]};
    return p;
  endfunction

  task automatic wait_drained();
    while (pending_angles != 0) @(posedge clk);
  endtask

  initial begin
    tpa_pts_t p;
    in_ch.valid = 1'b0;
    {in_ch.p1_x, in_ch.p1_y, in_ch.p1_z, in_ch.p2_x, in_ch.p2_y, in_ch.p2_z,
     in_ch.p3_x, in_ch.p3_y, in_ch.p3_z} = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: degenerate, right angle, parallel, extremes.
    send_points('0);
    send_points({32'sd5, 32'sd0, 32'sd0, 32'sd5, 32'sd0, 32'sd0, 32'sd9, 32'sd1, 32'sd1});
    send_points({32'sd1, 32'sd2, 32'sd3, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
    send_points({32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd0});
    send_points({32'sd0, 32'sd0, 32'sd7, 32'sd0, 32'sd0, 32'sd0, 32'sd3, 32'sd0, 32'sd0});
    send_points({32'sd1, 32'sd1, 32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd2, 32'sd2, 32'sd2});
    send_points({32'sd1, 32'sd1, 32'sd1, 32'sd0, 32'sd0, 32'sd0, -32'sd3, -32'sd3, -32'sd3});
    send_points({32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, -32'sd1, 32'sd0, 32'sd0});
    send_points({32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd1, 32'sd0});
    send_points({32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000});
    send_points({32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000});
    send_points({32'h80000000, 32'h00000000, 32'h7fffffff, 32'h7fffffff, 32'h00000000,
                 32'h80000000, 32'h7fffffff, 32'h00000001, 32'h80000000});
    send_points({32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h0, 32'h0, 32'h0,
                 32'h1, 32'h1, 32'h1});
    send_points({32'h7fffffff, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0});
    send_points({32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h80000000, 32'h1, 32'h0});

    // Random phases with different idle and stall mixes.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin send_idle_pct = 56; sink_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  sink_stall_pct = 56; end
        3: begin send_idle_pct = 6;  sink_stall_pct = 6;  end
        default: begin send_idle_pct = 0; sink_stall_pct = 0; end
      endcase
      if (ph == 4) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 250; n++) begin
        p = random_points();
        send_points(p);
      end
    end
    in_ch.valid <= 1'b0;

    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && pending_angles == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// File: filelist.f
design/tpa_pkg.sv
design/tpa_channels.sv
design/tpa_front.sv
design/tpa_sqrt_cell.sv
design/tpa_cordic_cell.sv
design/three_point_angle_core.sv
tb/tpa_angle_checker.sv
tb/tb_three_point_angle_core.sv
